/* src/b64_pkg.sv */
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the character classifier of the Base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSlash  = 8'h2f;

  localparam logic [5:0] SextetLowerBase = 6'd26;
  localparam logic [5:0] SextetDigitBase = 6'd52;
  localparam logic [5:0] SextetPlus      = 6'd62;
  localparam logic [5:0] SextetSlash     = 6'd63;

  // command queue depth
  localparam int CmdDepth   = 4;
  localparam int CmdPtrW    = $clog2(CmdDepth);
  localparam int CmdCountW  = $clog2(CmdDepth + 1);

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // one accepted character's worth of output: 0..3 bytes, plus end flag
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            msg_end;
  } cmd_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t    s;
    logic [7:0] d;
    s = '{ok: 1'b1, val: 6'd0};
    d = 8'd0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      d = ch - CharUpperA;
      s.val = d[5:0];
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      d = ch - CharLowerA;
      s.val = d[5:0] + SextetLowerBase;
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      d = ch - CharDigit0;
      s.val = d[5:0] + SextetDigitBase;
    end else if (ch == CharPlus) begin
      s.val = SextetPlus;
    end else if (ch == CharSlash) begin
      s.val = SextetSlash;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/b64_if.sv */
// ----------------------------------------------------------------------------
// b64_in_if / b64_out_if
// Valid/ready channels carrying encoded characters and decoded words.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       message_last;

  modport source (output valid, output text_char, output message_last, input ready);
  modport sink   (input valid, input text_char, input message_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output data_byte, output byte_valid, output run_last,
                  output message_end, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input run_last,
                  input message_end, output ready);
endinterface

`default_nettype wire

/* src/b64_front.sv */
// ----------------------------------------------------------------------------
// b64_front
// Classifies characters, assembles sextet groups and issues byte commands.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_text_char,
  input  wire logic          in_message_last,
  output logic               in_ready,
  input  wire logic          q_full,
  output logic               push,
  output b64_pkg::cmd_t      push_cmd
);

  logic [2:0][5:0] held_r, held_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            stopped_r, stopped_nxt;

  logic              accept;
  b64_pkg::sextet_t  sx;
  logic [2:0][5:0]   hs;    // held sextets including this character
  logic [1:0]        cnt;   // count after this character

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign sx       = b64_pkg::sextet_of(in_text_char);

  always_comb begin
    hs          = held_r;
    cnt         = count_r;
    stopped_nxt = stopped_r;
    push_cmd    = '0;
    if (!stopped_r) begin
      if (!sx.ok) begin
        stopped_nxt = 1'b1;
      end else if (count_r == 2'd3) begin
        push_cmd.bytes[0] = {held_r[0], held_r[1][5:4]};
        push_cmd.bytes[1] = {held_r[1][3:0], held_r[2][5:2]};
        push_cmd.bytes[2] = {held_r[2][1:0], sx.val};
        push_cmd.nbytes   = 2'd3;
        cnt               = 2'd0;
      end else begin
        hs[count_r] = sx.val;
        cnt         = count_r + 2'd1;
      end
    end
    if (in_message_last) begin
      push_cmd.msg_end = 1'b1;
      // partial group: n sextets give n-1 bytes
      if (cnt == 2'd2 || cnt == 2'd3) begin
        push_cmd.bytes[0] = {hs[0], hs[1][5:4]};
        push_cmd.nbytes   = 2'd1;
      end
      if (cnt == 2'd3) begin
        push_cmd.bytes[1] = {hs[1][3:0], hs[2][5:2]};
        push_cmd.nbytes   = 2'd2;
      end
      cnt         = 2'd0;
      stopped_nxt = 1'b0;
    end
    held_nxt  = hs;
    count_nxt = cnt;
  end

  assign push = accept && (push_cmd.nbytes != 2'd0 || in_message_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 2'd0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/b64_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// b64_cmd_fifo
// Short command queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire b64_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output b64_pkg::cmd_t      head_cmd,
  output logic               full,
  output logic               empty
);

  b64_pkg::cmd_t                     slot_r [b64_pkg::CmdDepth];
  logic [b64_pkg::CmdPtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [b64_pkg::CmdCountW-1:0]     count_r, count_nxt;

  assign full     = (count_r == b64_pkg::CmdCountW'(b64_pkg::CmdDepth));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* src/b64_back.sv */
// ----------------------------------------------------------------------------
// b64_back
// Unrolls each queued command into result words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire b64_pkg::cmd_t head_cmd,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_data_byte,
  output logic               out_byte_valid,
  output logic               out_run_last,
  output logic               out_message_end
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       bvalid_r, run_last_r, msg_end_r;
  logic [1:0] idx_r, idx_nxt;

  logic       load;
  logic [1:0] nres;
  logic       is_last;

  assign load    = (!valid_r || out_ready) && !q_empty;
  // a command without bytes still yields one (empty) word
  assign nres    = (head_cmd.nbytes == 2'd0) ? 2'd1 : head_cmd.nbytes;
  assign is_last = (idx_r == nres - 2'd1);
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r     <= (head_cmd.nbytes == 2'd0) ? 8'd0 : head_cmd.bytes[idx_r];
      bvalid_r   <= (head_cmd.nbytes != 2'd0);
      run_last_r <= is_last;
      msg_end_r  <= is_last && head_cmd.msg_end;
    end
  end

  assign out_valid       = valid_r;
  assign out_data_byte   = data_r;
  assign out_byte_valid  = bvalid_r;
  assign out_run_last    = run_last_r;
  assign out_message_end = msg_end_r;

endmodule

`default_nettype wire

/* src/base64_decoder_top.sv */
// ----------------------------------------------------------------------------
// base64_decoder_top
// Streaming Base64 decoder, standard alphabet, one character per word.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the command queue has room and
// delivers one result word per cycle while the output is ready. The front
// decodes a character in the cycle it is accepted and drops its 0 to 3
// bytes as one command into a four-entry command queue; the back drains
// that queue through a registered output stage, one word a cycle while the
// output is ready. Input ready drops only while the command queue is full.
// The first word of a character passes the command queue and the output
// register before it is valid. Every message end produces a word flagged
// message_end, with byte_valid low when there is no byte left to deliver.
`default_nettype none

module base64_decoder_top (
  input  wire logic clk,
  input  wire logic rst_n,
  b64_in_if.sink    in_ch,
  b64_out_if.source out_ch
);

  logic          push, pop, q_full, q_empty;
  b64_pkg::cmd_t push_cmd, head_cmd;
  logic          fe_ready;

  b64_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_text_char    (in_ch.text_char),
    .in_message_last (in_ch.message_last),
    .in_ready        (fe_ready),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  assign in_ch.ready = fe_ready;

  b64_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data_byte   (out_ch.data_byte),
    .out_byte_valid  (out_ch.byte_valid),
    .out_run_last    (out_ch.run_last),
    .out_message_end (out_ch.message_end)
  );

  // end of message always reaches the queue
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.message_last) |-> push)
    else $error("message end not queued");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full command queue");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.message_end) |-> out_ch.run_last)
    else $error("message end word not last of its run");

  a_empty_word_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.byte_valid) |-> out_ch.message_end)
    else $error("empty word outside message end");

endmodule

`default_nettype wire
